[hdl/ttu_pkg.sv]
`default_nettype none

package ttu_pkg;

    // field and datapath widths
    localparam int IN_W       = 16;
    localparam int OUT_W      = 32;
    localparam int DELTA_W    = IN_W + 1;
    localparam int ACC_W      = 2 * DELTA_W + 1;
    localparam int RES_FRAC   = 16;
    localparam int QUO_W      = OUT_W + 1;

    // serial step counts
    localparam int MUL_STEPS  = DELTA_W;
    localparam int MUL_CNT_W  = $clog2(MUL_STEPS);
    localparam int DVD_W      = ACC_W + RES_FRAC;
    localparam int DIV_STEPS  = DVD_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // saturation limits of a result component
    localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // control of the serial multiply-accumulate unit
    typedef struct packed {
        logic start;
        logic clear;
        logic subtract;
    } t_mac_ctl;

endpackage

`default_nettype wire

[hdl/ttu_mac.sv]
`default_nettype none

module ttu_mac (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire ttu_pkg::t_mac_ctl                      i_ctl,
    input  wire logic signed [ttu_pkg::DELTA_W-1:0]     i_a,
    input  wire logic signed [ttu_pkg::DELTA_W-1:0]     i_b,
    output logic                                        o_done,
    output logic signed [ttu_pkg::ACC_W-1:0]            o_acc
);
    import ttu_pkg::*;

    logic                      r_run, n_run;
    logic                      r_done, n_done;
    logic [MUL_CNT_W-1:0]      r_cnt, n_cnt;
    logic [ACC_W-1:0]          r_mcand, n_mcand;
    logic [DELTA_W-1:0]        r_mplier, n_mplier;
    logic [ACC_W-1:0]          r_acc, n_acc;
    logic                      r_sub, n_sub;
    logic [ACC_W-1:0]          term;
    logic                      last_bit;

    // one multiplier bit per cycle, the sign bit carries negative weight
    always_comb begin
        term     = r_mplier[0] ? r_mcand : '0;
        last_bit = (r_cnt == MUL_CNT_W'(MUL_STEPS - 1));
        n_run    = r_run;
        n_done   = 1'b0;
        n_cnt    = r_cnt;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_acc    = r_acc;
        n_sub    = r_sub;
        if (i_ctl.start) begin
            n_run    = 1'b1;
            n_cnt    = '0;
            n_mcand  = ACC_W'(i_a);
            n_mplier = i_b;
            n_sub    = i_ctl.subtract;
            if (i_ctl.clear) begin
                n_acc = '0;
            end
        end else if (r_run) begin
            if (r_sub ^ last_bit) begin
                n_acc = r_acc - term;
            end else begin
                n_acc = r_acc + term;
            end
            n_mcand  = r_mcand << 1;
            n_mplier = r_mplier >> 1;
            n_cnt    = r_cnt + 1'b1;
            if (last_bit) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
    end

    // shift and accumulate registers
    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_acc    <= n_acc;
        r_sub    <= n_sub;
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

`default_nettype wire

[hdl/ttu_div.sv]
`default_nettype none

module ttu_div (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_start,
    input  wire logic signed [ttu_pkg::ACC_W-1:0]       i_num,
    input  wire logic signed [ttu_pkg::ACC_W-1:0]       i_den,
    output logic                                        o_done,
    output logic [ttu_pkg::OUT_W-1:0]                   o_quot,
    output logic                                        o_clip
);
    import ttu_pkg::*;

    logic                      r_run, n_run;
    logic                      r_done, n_done;
    logic [DIV_CNT_W-1:0]      r_cnt, n_cnt;
    logic [DVD_W-1:0]          r_dvd, n_dvd;
    logic [ACC_W-1:0]          r_den, n_den;
    logic [ACC_W-1:0]          r_rem, n_rem;
    logic [QUO_W-1:0]          r_quo, n_quo;
    logic                      r_ovf, n_ovf;
    logic                      r_neg, n_neg;
    logic [ACC_W-1:0]          abs_num;
    logic [ACC_W-1:0]          abs_den;
    logic [ACC_W:0]            trial;
    logic                      fits;
    logic                      mag_hi;

    // magnitudes of the operands
    always_comb begin
        abs_num = i_num[ACC_W-1] ? ACC_W'(-i_num) : ACC_W'(i_num);
        abs_den = i_den[ACC_W-1] ? ACC_W'(-i_den) : ACC_W'(i_den);
    end

    // restoring division, one quotient bit per cycle
    always_comb begin
        trial  = {r_rem, r_dvd[DVD_W-1]};
        fits   = (trial >= {1'b0, r_den});
        n_run  = r_run;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_den  = r_den;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_ovf  = r_ovf;
        n_neg  = r_neg;
        if (i_start) begin
            n_run = 1'b1;
            n_cnt = '0;
            n_dvd = {abs_num, {RES_FRAC{1'b0}}};
            n_den = abs_den;
            n_rem = '0;
            n_quo = '0;
            n_ovf = 1'b0;
            n_neg = i_num[ACC_W-1] ^ i_den[ACC_W-1];
        end else if (r_run) begin
            n_rem = fits ? ACC_W'(trial - {1'b0, r_den}) : ACC_W'(trial);
            n_quo = {r_quo[QUO_W-2:0], fits};
            n_ovf = r_ovf | r_quo[QUO_W-1];
            n_dvd = r_dvd << 1;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_dvd <= n_dvd;
        r_den <= n_den;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_ovf <= n_ovf;
        r_neg <= n_neg;
    end

    // sign and saturation of the quotient
    always_comb begin
        mag_hi = r_ovf | r_quo[QUO_W-1];
        if (r_neg) begin
            o_clip = mag_hi | (r_quo[OUT_W-1] & (|r_quo[OUT_W-2:0]));
            o_quot = o_clip ? SAT_MIN : OUT_W'(~r_quo[OUT_W-1:0] + 1'b1);
        end else begin
            o_clip = mag_hi | r_quo[OUT_W-1];
            o_quot = o_clip ? SAT_MAX : r_quo[OUT_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

[hdl/triangle_tangent_from_uv_unit.sv]
// channel   signals                                  direction
// --------  ---------------------------------------  ---------
// vertex    i_valid, o_stall, i_pos_x/y/z, i_tex_u/v  in
// tangent   o_valid, i_stall, o_tangent_x/y/z,        out
//           o_degenerate, o_saturated
//
// The first and second vertex of a triangle are only held. The third vertex
// starts two determinant products on a serial multiply-accumulate unit at one
// multiplier bit per cycle; unless the determinant is zero, each component
// then takes two more products and one quotient on a serial divider at one
// quotient bit per cycle. Reset (synchronous, active low) starts a new
// triangle. A result held under i_stall does not block the next vertices;
// only the finishing triangle waits for the output register to free up.
`default_nettype none

module triangle_tangent_from_uv_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic signed [ttu_pkg::IN_W-1:0]     i_pos_x,
    input  wire logic signed [ttu_pkg::IN_W-1:0]     i_pos_y,
    input  wire logic signed [ttu_pkg::IN_W-1:0]     i_pos_z,
    input  wire logic signed [ttu_pkg::IN_W-1:0]     i_tex_u,
    input  wire logic signed [ttu_pkg::IN_W-1:0]     i_tex_v,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic signed [ttu_pkg::OUT_W-1:0]         o_tangent_x,
    output logic signed [ttu_pkg::OUT_W-1:0]         o_tangent_y,
    output logic signed [ttu_pkg::OUT_W-1:0]         o_tangent_z,
    output logic                                     o_degenerate,
    output logic                                     o_saturated
);
    import ttu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MAC  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } t_phase;

    // product schedule: two determinant terms, then two terms per component
    localparam logic [2:0] OP_DET_A = 3'd0;
    localparam logic [2:0] OP_DET_B = 3'd1;
    localparam logic [1:0] COMP_LAST = 2'd2;

    t_state                    r_state, n_state;
    t_phase                    r_phase, n_phase;
    logic [2:0]                r_op, n_op;
    logic [1:0]                r_comp, n_comp;
    logic                      r_mac_go, n_mac_go;
    logic                      r_div_go, n_div_go;
    logic                      r_deg, n_deg;
    logic                      r_sat, n_sat;
    logic                      r_out_valid, n_out_valid;

    logic signed [IN_W-1:0]    r_pos0 [3];
    logic signed [IN_W-1:0]    r_pos1 [3];
    logic signed [IN_W-1:0]    r_u0, r_v0, r_u1, r_v1;
    logic signed [DELTA_W-1:0] r_du1, r_dv1, r_du2, r_dv2;
    logic signed [DELTA_W-1:0] r_e1 [3];
    logic signed [DELTA_W-1:0] r_e2 [3];
    logic signed [ACC_W-1:0]   r_det;
    logic [OUT_W-1:0]          r_res [3];
    logic [OUT_W-1:0]          r_out_t [3];
    logic                      r_out_deg, r_out_sat;

    logic signed [IN_W-1:0]    in_pos [3];
    logic                      in_take;
    logic                      out_take;
    logic                      out_load;
    t_mac_ctl                  mac_ctl;
    logic signed [DELTA_W-1:0] mac_a, mac_b;
    logic                      mac_done;
    logic signed [ACC_W-1:0]   mac_acc;
    logic                      div_done;
    logic [OUT_W-1:0]          div_quot;
    logic                      div_clip;

    assign in_pos[0] = i_pos_x;
    assign in_pos[1] = i_pos_y;
    assign in_pos[2] = i_pos_z;

    // handshakes
    assign o_stall  = (r_state != S_IDLE);
    assign in_take  = i_valid & ~o_stall;
    assign out_take = r_out_valid & ~i_stall;
    assign out_load = (r_state == S_OUT) & (~r_out_valid | ~i_stall);

    // operand selection for the product in progress
    always_comb begin
        if (r_op == OP_DET_A) begin
            mac_a = r_du1;
            mac_b = r_dv2;
        end else if (r_op == OP_DET_B) begin
            mac_a = r_du2;
            mac_b = r_dv1;
        end else if (!r_op[0]) begin
            mac_a = r_dv2;
            mac_b = r_e1[r_comp];
        end else begin
            mac_a = r_dv1;
            mac_b = r_e2[r_comp];
        end
        mac_ctl.start    = r_mac_go;
        mac_ctl.clear    = ~r_op[0];
        mac_ctl.subtract = r_op[0];
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_op        = r_op;
        n_comp      = r_comp;
        n_mac_go    = 1'b0;
        n_div_go    = 1'b0;
        n_deg       = r_deg;
        n_sat       = r_sat;
        n_out_valid = (r_out_valid & i_stall) | out_load;
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    case (r_phase)
                        PH_SECOND: begin
                            n_phase = PH_THIRD;
                        end
                        PH_THIRD: begin
                            n_phase  = PH_FIRST;
                            n_op     = OP_DET_A;
                            n_comp   = '0;
                            n_deg    = 1'b0;
                            n_sat    = 1'b0;
                            n_mac_go = 1'b1;
                            n_state  = S_MAC;
                        end
                        default: begin
                            n_phase = PH_SECOND;
                        end
                    endcase
                end
            end
            S_MAC: begin
                if (mac_done) begin
                    if (r_op == OP_DET_B) begin
                        if (mac_acc == '0) begin
                            n_deg   = 1'b1;
                            n_state = S_OUT;
                        end else begin
                            n_op     = r_op + 1'b1;
                            n_mac_go = 1'b1;
                        end
                    end else if (r_op[0]) begin
                        n_div_go = 1'b1;
                        n_state  = S_DIV;
                    end else begin
                        n_op     = r_op + 1'b1;
                        n_mac_go = 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_sat = r_sat | div_clip;
                    if (r_comp == COMP_LAST) begin
                        n_state = S_OUT;
                    end else begin
                        n_comp   = r_comp + 1'b1;
                        n_op     = r_op + 1'b1;
                        n_mac_go = 1'b1;
                        n_state  = S_MAC;
                    end
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_FIRST;
            r_op        <= OP_DET_A;
            r_comp      <= '0;
            r_mac_go    <= 1'b0;
            r_div_go    <= 1'b0;
            r_deg       <= 1'b0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_op        <= n_op;
            r_comp      <= n_comp;
            r_mac_go    <= n_mac_go;
            r_div_go    <= n_div_go;
            r_deg       <= n_deg;
            r_sat       <= n_sat;
            r_out_valid <= n_out_valid;
        end
    end

    // held vertices and deltas of the third vertex
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            case (r_phase)
                PH_SECOND: begin
                    for (int c = 0; c < 3; c++) begin
                        r_pos1[c] <= in_pos[c];
                    end
                    r_u1 <= i_tex_u;
                    r_v1 <= i_tex_v;
                end
                PH_THIRD: begin
                    for (int c = 0; c < 3; c++) begin
                        r_e1[c] <= DELTA_W'(r_pos1[c]) - DELTA_W'(r_pos0[c]);
                        r_e2[c] <= DELTA_W'(in_pos[c]) - DELTA_W'(r_pos0[c]);
                    end
                    r_du1 <= DELTA_W'(r_u1) - DELTA_W'(r_u0);
                    r_dv1 <= DELTA_W'(r_v1) - DELTA_W'(r_v0);
                    r_du2 <= DELTA_W'(i_tex_u) - DELTA_W'(r_u0);
                    r_dv2 <= DELTA_W'(i_tex_v) - DELTA_W'(r_v0);
                end
                default: begin
                    for (int c = 0; c < 3; c++) begin
                        r_pos0[c] <= in_pos[c];
                    end
                    r_u0 <= i_tex_u;
                    r_v0 <= i_tex_v;
                end
            endcase
        end
    end

    // determinant and quotient capture
    always_ff @(posedge i_clk) begin
        if ((r_state == S_MAC) && mac_done && (r_op == OP_DET_B)) begin
            r_det <= mac_acc;
        end
        if ((r_state == S_DIV) && div_done) begin
            r_res[r_comp] <= div_quot;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            for (int c = 0; c < 3; c++) begin
                r_out_t[c] <= r_deg ? '0 : r_res[c];
            end
            r_out_deg <= r_deg;
            r_out_sat <= r_deg ? 1'b0 : r_sat;
        end
    end

    ttu_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_done  (mac_done),
        .o_acc   (mac_acc)
    );

    ttu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (mac_acc),
        .i_den   (r_det),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_clip  (div_clip)
    );

    assign o_valid      = r_out_valid;
    assign o_tangent_x  = r_out_t[0];
    assign o_tangent_y  = r_out_t[1];
    assign o_tangent_z  = r_out_t[2];
    assign o_degenerate = r_out_deg;
    assign o_saturated  = r_out_sat;

endmodule

`default_nettype wire
